@@ rtl/led_bar_meter_peak_hold_assert.svh @@
// Assertion macros shared by the LED bar meter modules.
`ifndef LED_BAR_METER_PEAK_HOLD_ASSERT_SVH
`define LED_BAR_METER_PEAK_HOLD_ASSERT_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define LBM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define LBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lbm_pkg.sv @@
// Types and constants of the LED bar meter with peak hold.
package lbm_pkg;

  localparam int LBM_CHANNELS    = 8;
  localparam int LBM_SAMPLE_BITS = 12;
  localparam int CHAN_BITS       = 3;
  localparam int BAR_BITS        = 8;
  localparam int THR_BITS        = 12;
  localparam int HOLD_BITS       = 8;
  localparam int CFG_WIDTH       = 12;
  localparam int CFG_IDX_BITS    = 2;
  localparam int LBM_QDEPTH      = 2;

  localparam logic [THR_BITS-1:0]  OFF_THRESHOLD_RST = 12'd0;
  localparam logic [THR_BITS-1:0]  LED_STEP_RST      = 12'd64;
  localparam logic [HOLD_BITS-1:0] PEAK_HOLD_RST     = 8'd20;
  localparam logic [HOLD_BITS-1:0] DECAY_HOLD_RST    = 8'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_OFF_THRESHOLD = 2'd0,
    CFG_LED_STEP      = 2'd1,
    CFG_PEAK_HOLD     = 2'd2,
    CFG_DECAY_HOLD    = 2'd3
  } lbm_cfg_idx_e;

  typedef struct packed {
    logic [THR_BITS-1:0]  off_threshold;
    logic [THR_BITS-1:0]  led_step;
    logic [HOLD_BITS-1:0] peak_hold_ticks;
    logic [HOLD_BITS-1:0] decay_hold_ticks;
  } lbm_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV   = 2'd1,
    ST_WRITE = 2'd2
  } lbm_state_e;

endpackage

@@ rtl/led_bar_meter_peak_hold.sv @@
// Top level of the per-channel LED bar meter with peak hold and stepwise decay.
//
// Samples enter through a queue-like port: an item is taken when push is high and
// full is low. Each item names a channel and an amplitude; items for channels at or
// above CHANNELS are taken and dropped without a result. Every other item gives one
// result on the output queue: the channel, its bar length in LEDs and the peak flag.
// A result waits while empty is low and leaves when pop is high.
// The back part divides by the LED step one quotient bit per cycle; an amplitude
// at or below the threshold, or a zero step, skips the divide. The back part
// takes no new item until the result of the last one is on the output queue.
// Two-entry queues stand on each side of the divider, so a stalled receiver first
// fills the result queue, then halts the divider, then asserts full.
// Configuration writes take effect on the next cycle. The user must make them
// only while idle; the block itself does not enforce this.
// Reset clears all bars, hold counts and peak flags and loads the register defaults.
module led_bar_meter_peak_hold
  import lbm_pkg::*;
#(
  parameter int CHANNELS    = LBM_CHANNELS,
  parameter int SAMPLE_BITS = LBM_SAMPLE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]    cfg_wdata_i,
  input  logic                    push,
  output logic                    full,
  input  logic [CHAN_BITS-1:0]    channel_i,
  input  logic [SAMPLE_BITS-1:0]  amplitude_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [CHAN_BITS-1:0]    out_channel_o,
  output logic [BAR_BITS-1:0]     bar_leds_o,
  output logic                    fresh_peak_o
);

  localparam int CMD_W = SAMPLE_BITS + 4;
  localparam int RES_W = CHAN_BITS + BAR_BITS + 1;

  lbm_cfg_t cfg_q;

  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  logic [CMD_W-1:0] cmd_in;
  logic [CMD_W-1:0] cmd_out;
  logic             res_push;
  logic             res_full;
  logic [RES_W-1:0] res_in;
  logic [RES_W-1:0] res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_threshold    <= OFF_THRESHOLD_RST;
      cfg_q.led_step         <= LED_STEP_RST;
      cfg_q.peak_hold_ticks  <= PEAK_HOLD_RST;
      cfg_q.decay_hold_ticks <= DECAY_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (lbm_cfg_idx_e'(cfg_idx_i))
        CFG_OFF_THRESHOLD: cfg_q.off_threshold    <= cfg_wdata_i[THR_BITS-1:0];
        CFG_LED_STEP:      cfg_q.led_step         <= cfg_wdata_i[THR_BITS-1:0];
        CFG_PEAK_HOLD:     cfg_q.peak_hold_ticks  <= cfg_wdata_i[HOLD_BITS-1:0];
        CFG_DECAY_HOLD:    cfg_q.decay_hold_ticks <= cfg_wdata_i[HOLD_BITS-1:0];
        default:           cfg_q                  <= cfg_q;
      endcase
    end
  end

  lbm_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .push_i          (push),
    .full_o          (full),
    .channel_i       (channel_i),
    .amplitude_i     (amplitude_i),
    .off_threshold_i (cfg_q.off_threshold),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_data_o      (cmd_in)
  );

  lbm_queue #(
    .WIDTH (CMD_W)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  lbm_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_data_i  (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_in)
  );

  lbm_queue #(
    .WIDTH (RES_W)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_channel_o = res_out[RES_W-1:BAR_BITS+1];
  assign bar_leds_o    = res_out[BAR_BITS:1];
  assign fresh_peak_o  = res_out[0];

endmodule

@@ rtl/lbm_queue.sv @@
// Small first-in first-out queue of items between pipeline parts.
module lbm_queue
  import lbm_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (LBM_QDEPTH > 1) ? $clog2(LBM_QDEPTH) : 1;
  localparam int CNT_W = $clog2(LBM_QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(LBM_QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LBM_QDEPTH);

  logic [WIDTH-1:0] mem_q [LBM_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`include "led_bar_meter_peak_hold_assert.svh"

  `LBM_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty_o, "queue empty after a push")

endmodule

@@ rtl/lbm_front.sv @@
// Front part: accepts samples, drops unknown channels and compares against the threshold.
module lbm_front
  import lbm_pkg::*;
#(
  parameter int CHANNELS    = LBM_CHANNELS,
  parameter int SAMPLE_BITS = LBM_SAMPLE_BITS
) (
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [CHAN_BITS-1:0]     channel_i,
  input  logic [SAMPLE_BITS-1:0]   amplitude_i,
  input  logic [THR_BITS-1:0]      off_threshold_i,
  input  logic                     cmd_full_i,
  output logic                     cmd_push_o,
  output logic [SAMPLE_BITS+3:0]   cmd_data_o
);

  localparam int NUM_CH = (CHANNELS < (2 ** CHAN_BITS)) ? CHANNELS : (2 ** CHAN_BITS);
  localparam int CMP_W  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam logic [CHAN_BITS:0] NUM_CH_L = (CHAN_BITS + 1)'(NUM_CH);

  logic             chan_ok;
  logic             below;
  logic [CMP_W-1:0] amp_w;
  logic [CMP_W-1:0] off_w;
  logic [CMP_W-1:0] diff_w;

  assign amp_w   = CMP_W'(amplitude_i);
  assign off_w   = CMP_W'(off_threshold_i);
  assign below   = (amp_w <= off_w);
  assign diff_w  = amp_w - off_w;
  assign chan_ok = ({1'b0, channel_i} < NUM_CH_L);

  // Items for channels that do not exist are taken and dropped.
  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i && chan_ok;
  assign cmd_data_o = {channel_i, below, diff_w[SAMPLE_BITS-1:0]};

endmodule

@@ rtl/lbm_back.sv @@
// Back part: serial divide by the LED step and per-channel bar, hold and peak update.
module lbm_back
  import lbm_pkg::*;
#(
  parameter int CHANNELS    = LBM_CHANNELS,
  parameter int SAMPLE_BITS = LBM_SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lbm_cfg_t                          cfg_i,
  input  logic                              cmd_empty_i,
  input  logic [SAMPLE_BITS+3:0]            cmd_data_i,
  output logic                              cmd_pop_o,
  input  logic                              res_full_i,
  output logic                              res_push_o,
  output logic [CHAN_BITS+BAR_BITS:0]       res_data_o
);

  localparam int NUM_CH = (CHANNELS < (2 ** CHAN_BITS)) ? CHANNELS : (2 ** CHAN_BITS);
  localparam int IDX_W  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
  localparam int CNT_W  = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAT_Q = SAMPLE_BITS'(255);

  lbm_state_e state_q, state_d;

  logic [CHAN_BITS-1:0]   cmd_chan;
  logic                   cmd_below;
  logic [SAMPLE_BITS-1:0] cmd_diff;
  logic                   direct;
  logic                   div_last;

  logic [CHAN_BITS-1:0]   ch_q;
  logic [SAMPLE_BITS-1:0] dvd_q;
  logic [SAMPLE_BITS-1:0] quo_q;
  logic [SAMPLE_BITS-1:0] quo_d;
  logic [THR_BITS-1:0]    rem_q;
  logic [THR_BITS:0]      trial;
  logic [THR_BITS:0]      trial_sub;
  logic                   trial_ge;
  logic [CNT_W-1:0]       cnt_q;
  logic [BAR_BITS-1:0]    tgt_q;

  logic [BAR_BITS-1:0]  bar_q  [NUM_CH];
  logic [HOLD_BITS-1:0] hold_q [NUM_CH];
  logic                 peak_q [NUM_CH];

  logic [IDX_W-1:0]     idx;
  logic [BAR_BITS-1:0]  cur_bar;
  logic [HOLD_BITS-1:0] cur_hold;
  logic                 cur_peak;
  logic [HOLD_BITS-1:0] limit;
  logic [BAR_BITS-1:0]  upd_bar;
  logic [HOLD_BITS-1:0] upd_hold;
  logic                 upd_peak;

  assign cmd_chan  = cmd_data_i[SAMPLE_BITS+3:SAMPLE_BITS+1];
  assign cmd_below = cmd_data_i[SAMPLE_BITS];
  assign cmd_diff  = cmd_data_i[SAMPLE_BITS-1:0];
  assign direct    = cmd_below || (cfg_i.led_step == '0);
  assign div_last  = (cnt_q == LAST_CNT);

  assign trial     = {rem_q, dvd_q[SAMPLE_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, cfg_i.led_step});
  assign trial_sub = trial - {1'b0, cfg_i.led_step};
  assign quo_d     = {quo_q[SAMPLE_BITS-2:0], trial_ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = direct ? ST_WRITE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE:  cmd_pop_o  = !cmd_empty_i;
      ST_DIV:   cmd_pop_o  = 1'b0;
      ST_WRITE: res_push_o = !res_full_i;
      default: begin
        cmd_pop_o  = 1'b0;
        res_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      ch_q  <= cmd_chan;
      dvd_q <= cmd_diff;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
      tgt_q <= cmd_below ? BAR_BITS'(1) : '1;
    end else if (state_q == ST_DIV) begin
      dvd_q <= {dvd_q[SAMPLE_BITS-2:0], 1'b0};
      rem_q <= trial_ge ? trial_sub[THR_BITS-1:0] : trial[THR_BITS-1:0];
      quo_q <= quo_d;
      cnt_q <= cnt_q + 1'b1;
      if (div_last) begin
        tgt_q <= (quo_d > SAT_Q) ? '1 : quo_d[BAR_BITS-1:0];
      end
    end
  end

  assign idx      = ch_q[IDX_W-1:0];
  assign cur_bar  = bar_q[idx];
  assign cur_hold = hold_q[idx];
  assign cur_peak = peak_q[idx];
  assign limit    = cur_peak ? cfg_i.peak_hold_ticks : cfg_i.decay_hold_ticks;

  // The hold count is left as it is when the bar rises.
  always_comb begin
    upd_bar  = cur_bar;
    upd_hold = cur_hold;
    upd_peak = cur_peak;
    if (tgt_q < cur_bar) begin
      if (cur_hold < limit) begin
        upd_hold = cur_hold + 1'b1;
      end else begin
        upd_hold = '0;
        upd_bar  = cur_bar - 1'b1;
        upd_peak = 1'b0;
      end
    end else begin
      upd_bar  = tgt_q;
      upd_peak = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        bar_q[i]  <= '0;
        hold_q[i] <= '0;
        peak_q[i] <= 1'b0;
      end
    end else if (res_push_o) begin
      bar_q[idx]  <= upd_bar;
      hold_q[idx] <= upd_hold;
      peak_q[idx] <= upd_peak;
    end
  end

  assign res_data_o = {ch_q, upd_bar, upd_peak};

`include "led_bar_meter_peak_hold_assert.svh"

  `LBM_ASSERT_SAME(a_div_count, state_q == ST_DIV, cnt_q < CNT_W'(SAMPLE_BITS), "divide overran")
  `LBM_ASSERT_SAME(a_push_room, res_push_o, !res_full_i && state_q == ST_WRITE, "bad result push")
  `LBM_ASSERT_NEXT(a_pop_busy, cmd_pop_o, state_q != ST_IDLE, "idle after taking an item")

endmodule

@@ tb/led_bar_meter_peak_hold_test.sv @@
// Self-checking testbench for the per-channel LED bar meter with peak hold and decay.
module led_bar_meter_peak_hold_test;
  import lbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned AMP_MAX     = (1 << LBM_SAMPLE_BITS) - 1;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 240;
  localparam int          MAX_REPORTS = 200;

  typedef struct packed {
    logic [CHAN_BITS-1:0]       chan;
    logic [LBM_SAMPLE_BITS-1:0] amp;
  } sample_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] chan;
    logic [BAR_BITS-1:0]  leds;
    logic                 peak;
  } bar_update_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]    cfg_idx_i   = CFG_OFF_THRESHOLD;
  logic [CFG_WIDTH-1:0]       cfg_wdata_i = '0;
  logic                       push        = 1'b0;
  logic                       full;
  logic [CHAN_BITS-1:0]       channel_i   = '0;
  logic [LBM_SAMPLE_BITS-1:0] amplitude_i = '0;
  logic                       empty;
  logic                       pop         = 1'b0;
  logic [CHAN_BITS-1:0]       out_channel_o;
  logic [BAR_BITS-1:0]        bar_leds_o;
  logic                       fresh_peak_o;

  lbm_cfg_t            meter_cfg = '{OFF_THRESHOLD_RST, LED_STEP_RST, PEAK_HOLD_RST,
                                     DECAY_HOLD_RST};
  logic [BAR_BITS-1:0]  bar_q  [LBM_CHANNELS] = '{default: '0};
  logic [HOLD_BITS-1:0] hold_q [LBM_CHANNELS] = '{default: '0};
  logic                 peak_q [LBM_CHANNELS] = '{default: 1'b0};

  sample_t     samples_to_send [$];
  bar_update_t updates_due     [$];

  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_drops    = 0;
  int unsigned n_errors   = 0;
  int unsigned n_settings = 0;
  int unsigned cycles     = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  led_bar_meter_peak_hold i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .channel_i    (channel_i),
    .amplitude_i  (amplitude_i),
    .empty        (empty),
    .pop          (pop),
    .out_channel_o(out_channel_o),
    .bar_leds_o   (bar_leds_o),
    .fresh_peak_o (fresh_peak_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic bar_update_t update_bar(input sample_t s);
    int unsigned amp;
    int unsigned thr;
    int unsigned step;
    int unsigned goal;
    int unsigned limit;
    bar_update_t r;
    amp  = s.amp;
    thr  = meter_cfg.off_threshold;
    step = meter_cfg.led_step;
    if (amp <= thr) begin
      goal = 1;
    end else if (step == 0) begin
      goal = 255;
    end else begin
      goal = (amp - thr) / step;
      if (goal > 255) goal = 255;
    end
    if (goal < bar_q[s.chan]) begin
      limit = peak_q[s.chan] ? meter_cfg.peak_hold_ticks : meter_cfg.decay_hold_ticks;
      if (hold_q[s.chan] < limit) begin
        hold_q[s.chan] = hold_q[s.chan] + 1'b1;
      end else begin
        hold_q[s.chan] = '0;
        bar_q[s.chan]  = bar_q[s.chan] - 1'b1;
        peak_q[s.chan] = 1'b0;
        n_drops++;
      end
    end else begin
      bar_q[s.chan]  = BAR_BITS'(goal);
      peak_q[s.chan] = 1'b1;
    end
    r.chan = s.chan;
    r.leds = bar_q[s.chan];
    r.peak = peak_q[s.chan];
    return r;
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    sample_t nxt;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        updates_due.push_back(update_bar('{channel_i, amplitude_i}));
        n_accepted++;
        if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
        gap_left = pick_gap(send_burst);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (samples_to_send.size() > 0) begin
        nxt = samples_to_send.pop_front();
        push        <= 1'b1;
        channel_i   <= nxt.chan;
        amplitude_i <= nxt.amp;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    bar_update_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (updates_due.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: unexpected result: channel %0d leds %0d peak %0b", $time,
                     out_channel_o, bar_leds_o, fresh_peak_o);
        end else begin
          want = updates_due.pop_front();
          n_checked++;
          if (out_channel_o !== want.chan) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: out_channel expected %0d actual %0d", $time, want.chan,
                       out_channel_o);
          end
          if (bar_leds_o !== want.leds) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: bar_leds on channel %0d expected %0d actual %0d", $time,
                       want.chan, want.leds, bar_leds_o);
          end
          if (fresh_peak_o !== want.peak) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("%0t: fresh_peak on channel %0d expected %0b actual %0b", $time,
                       want.chan, want.peak, fresh_peak_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) take_burst = !take_burst;
        stall_left = pick_gap(take_burst);
        pop <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, updates_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_sample(input int unsigned chan, input int unsigned amp);
    samples_to_send.push_back('{CHAN_BITS'(chan), LBM_SAMPLE_BITS'(amp)});
    n_queued++;
  endtask

  task automatic write_reg(input lbm_cfg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_WIDTH'(value);
    case (idx)
      CFG_OFF_THRESHOLD: meter_cfg.off_threshold    = THR_BITS'(value);
      CFG_LED_STEP:      meter_cfg.led_step         = THR_BITS'(value);
      CFG_PEAK_HOLD:     meter_cfg.peak_hold_ticks  = HOLD_BITS'(value);
      CFG_DECAY_HOLD:    meter_cfg.decay_hold_ticks = HOLD_BITS'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_meter(input int unsigned thr, input int unsigned step,
                           input int unsigned peak, input int unsigned decay);
    write_reg(CFG_OFF_THRESHOLD, thr);
    write_reg(CFG_LED_STEP, step);
    write_reg(CFG_PEAK_HOLD, peak);
    write_reg(CFG_DECAY_HOLD, decay);
    n_settings++;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (n_accepted != n_queued || updates_due.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  // Mostly a loud sample followed by mostly quieter ones on the same channel, so that bars
  // hold and decay; the rest are single samples anywhere in range.
  task automatic add_random_samples(input int count);
    int left;
    int chan;
    int len;
    int unsigned top;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 3) begin
        add_sample($urandom_range(0, LBM_CHANNELS - 1), $urandom_range(0, AMP_MAX));
        left--;
      end else begin
        chan = $urandom_range(0, LBM_CHANNELS - 1);
        len  = $urandom_range(2, 30);
        top  = meter_cfg.off_threshold + meter_cfg.led_step * $urandom_range(1, 40)
               + $urandom_range(0, 3);
        if (top > AMP_MAX) top = ($urandom_range(0, 1) == 1) ? AMP_MAX
                                                                : $urandom_range(0, AMP_MAX);
        add_sample(chan, top);
        for (int k = 1; k < len; k++) begin
          if ($urandom_range(0, 99) < 85) add_sample(chan, $urandom_range(0, top));
          else add_sample(chan, $urandom_range(top, AMP_MAX));
        end
        left -= len;
      end
    end
  endtask

  initial begin
    int unsigned thr;
    int unsigned step;
    int unsigned peak;
    int unsigned decay;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: full scale, a sample at the threshold, a target of zero
    // that only holds, and a rising bar.
    n_settings++;
    add_sample(0, AMP_MAX);
    add_sample(7, 0);
    add_sample(7, 63);
    add_sample(3, 64);
    add_sample(3, AMP_MAX);
    wait_drained();

    // Unit step saturates the target; zero hold counts drop a bar on every low sample.
    set_meter(0, 1, 0, 0);
    add_sample(1, AMP_MAX);
    add_sample(1, 0);
    add_sample(1, 0);
    add_sample(1, 300);
    add_sample(2, 2048);
    add_sample(0, 0);
    wait_drained();

    // Largest threshold and step: every sample shows one LED.
    set_meter(AMP_MAX, AMP_MAX, 255, 255);
    add_sample(4, AMP_MAX);
    add_sample(4, 0);
    add_sample(5, 12'haaa);
    add_sample(6, 12'h555);
    wait_drained();

    // A zero step sends any sample above the threshold to full scale.
    set_meter(100, 0, 1, 0);
    add_sample(2, 101);
    add_sample(2, 100);
    add_sample(2, 0);
    add_sample(2, 0);
    add_sample(5, AMP_MAX);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      thr   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2047);
      step  = ($urandom_range(0, 3) == 0) ? $urandom_range(65, AMP_MAX)
                                          : $urandom_range(1, 64);
      peak  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
      decay = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      set_meter(thr, step, peak, decay);
      add_random_samples(PHASE_ITEMS);
      wait_drained();
    end

    $display("Sent %0d samples under %0d register settings.", n_queued, n_settings);
    $display("Checked %0d bar updates, %0d of them one-LED drops.", n_checked, n_drops);
    if (n_errors == 0 && updates_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
